// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock, off while reset is low
`define SFP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define SFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/sfp_pkg.sv =====
// package with word types, op codes and register defaults for the frame parser
package sfp_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

	localparam logic [7:0]  SYNC_FIRST_RST    = 8'h55;
	localparam logic [7:0]  SYNC_SECOND_RST   = 8'hAA;
	localparam logic [7:0]  MAX_LENGTH_RST    = 8'd250;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

	localparam logic [1:0] OP_BYTE = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
		logic [7:0] read_index;
	} in_word_t;

	typedef struct packed {
		logic       frame_valid;
		logic [7:0] frame_port;
		logic [7:0] frame_length;
		logic [7:0] read_data;
		logic       in_frame;
	} out_word_t;

endpackage

// ===== sv/sync_frame_parser_top.sv =====
// sync/header/length/checksum frame parser with payload store
// an accepted word is held in the input register, then goes through the compute stage into the result register
// accepts one word per cycle, limited only by the result register being taken
// the parse state and payload store update in the single compute stage
// reset: parser idle, counters and config registers at their default values
// payload store is not cleared; entries are defined once written
module sync_frame_parser_top #(
	parameter int PAYLOAD_DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [sfp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [sfp_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  sfp_pkg::in_word_t                      in_word,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output sfp_pkg::out_word_t                     out_word
);

	localparam int AW = $clog2(PAYLOAD_DEPTH);

	typedef logic [AW-1:0] wrap_tab_t [256];

	function automatic wrap_tab_t mk_wrap_tab();
		wrap_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = AW'(i % PAYLOAD_DEPTH);
		end
		return t;
	endfunction

	localparam wrap_tab_t WRAP_TAB = mk_wrap_tab();

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SYNC2,
		PH_PORT,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	// config registers
	logic [7:0]  sync_first_q;
	logic [7:0]  sync_second_q;
	logic [7:0]  max_length_q;
	logic [15:0] timeout_ticks_q;

	// input stage
	logic              valid_s1;
	sfp_pkg::in_word_t word_s1;

	// parser state
	phase_t      phase_q, phase_d;
	logic [7:0]  port_q, port_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  byte_index_q, byte_index_d;
	logic [AW-1:0] wr_ptr_q, wr_ptr_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] tick_inc;
	logic [7:0]  byte_index_inc;
	logic [7:0]  sum_add;
	logic        frame_ok;
	logic        mem_we;

	// result register
	logic       res_valid_q;
	logic       frame_valid_q;
	logic [7:0] frame_port_q;
	logic [7:0] frame_length_q;
	logic       rd_en_q;
	logic [7:0] mem_rd_q;
	logic       in_frame_q;

	logic [7:0] mem [PAYLOAD_DEPTH];

	logic adv;

	assign adv      = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q    <= sfp_pkg::SYNC_FIRST_RST;
			sync_second_q   <= sfp_pkg::SYNC_SECOND_RST;
			max_length_q    <= sfp_pkg::MAX_LENGTH_RST;
			timeout_ticks_q <= sfp_pkg::TIMEOUT_TICKS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sfp_pkg::CFG_SYNC_FIRST:    sync_first_q    <= cfg_data[7:0];
				sfp_pkg::CFG_SYNC_SECOND:   sync_second_q   <= cfg_data[7:0];
				sfp_pkg::CFG_MAX_LENGTH:    max_length_q    <= cfg_data[7:0];
				sfp_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	assign tick_inc       = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign byte_index_inc = byte_index_q + 8'd1;
	assign sum_add        = sum_q + word_s1.data_byte;

	always_comb begin
		phase_d      = phase_q;
		port_d       = port_q;
		length_d     = length_q;
		byte_index_d = byte_index_q;
		wr_ptr_d     = wr_ptr_q;
		sum_d        = sum_q;
		tick_d       = tick_q;
		frame_ok     = 1'b0;
		mem_we       = 1'b0;
		unique case (word_s1.op)
			sfp_pkg::OP_BYTE: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (word_s1.data_byte == sync_first_q) begin
							phase_d = PH_SYNC2;
						end
					end
					PH_SYNC2: begin
						if (word_s1.data_byte == sync_second_q) begin
							phase_d = PH_PORT;
						end else if (word_s1.data_byte != sync_first_q) begin
							phase_d = PH_IDLE;
							tick_d  = '0;
						end
					end
					PH_PORT: begin
						port_d  = word_s1.data_byte;
						sum_d   = word_s1.data_byte;
						phase_d = PH_LEN;
					end
					PH_LEN: begin
						if (word_s1.data_byte > max_length_q) begin
							phase_d = PH_IDLE;
							tick_d  = '0;
						end else begin
							length_d     = word_s1.data_byte;
							byte_index_d = '0;
							wr_ptr_d     = '0;
							sum_d        = sum_add;
							phase_d      = (word_s1.data_byte == 8'd0) ? PH_SUM : PH_DATA;
						end
					end
					PH_DATA: begin
						mem_we       = 1'b1;
						byte_index_d = byte_index_inc;
						wr_ptr_d     = (wr_ptr_q == AW'(PAYLOAD_DEPTH - 1)) ? '0
							: wr_ptr_q + AW'(1);
						sum_d        = sum_add;
						if (byte_index_inc >= length_q) begin
							phase_d = PH_SUM;
						end
					end
					PH_SUM: begin
						frame_ok = (sum_q == word_s1.data_byte);
						phase_d  = PH_IDLE;
						tick_d   = '0;
					end
					default: begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end
				endcase
			end
			sfp_pkg::OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_inc > timeout_ticks_q) begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
					end
				end else begin
					tick_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			port_q         <= '0;
			length_q       <= '0;
			byte_index_q   <= '0;
			wr_ptr_q       <= '0;
			sum_q          <= '0;
			tick_q         <= '0;
			res_valid_q    <= 1'b0;
			frame_valid_q  <= 1'b0;
			frame_port_q   <= '0;
			frame_length_q <= '0;
			rd_en_q        <= 1'b0;
			in_frame_q     <= 1'b0;
		end else begin
			if (adv) begin
				phase_q        <= phase_d;
				port_q         <= port_d;
				length_q       <= length_d;
				byte_index_q   <= byte_index_d;
				wr_ptr_q       <= wr_ptr_d;
				sum_q          <= sum_d;
				tick_q         <= tick_d;
				res_valid_q    <= 1'b1;
				frame_valid_q  <= frame_ok;
				frame_port_q   <= frame_ok ? port_q : '0;
				frame_length_q <= frame_ok ? length_q : '0;
				rd_en_q        <= (word_s1.op == sfp_pkg::OP_READ);
				in_frame_q     <= (phase_d != PH_IDLE);
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mem_we) begin
			mem[wr_ptr_q] <= word_s1.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mem_rd_q <= mem[WRAP_TAB[word_s1.read_index]];
		end
	end

	assign out_valid = res_valid_q;

	always_comb begin
		out_word.frame_valid  = frame_valid_q;
		out_word.frame_port   = frame_port_q;
		out_word.frame_length = frame_length_q;
		out_word.read_data    = rd_en_q ? mem_rd_q : 8'd0;
		out_word.in_frame     = in_frame_q;
	end

endmodule

// ===== sv/sfp_checker.sv =====
// port-level checker for the frame parser, bound to the top level
`include "assert_macros.svh"

module sfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input sfp_pkg::out_word_t out_word
);

	`SFP_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result word changed")
	`SFP_ASSERT_IMPL(a_frame_ends_idle, clk, arst_n, out_valid && out_word.frame_valid, !out_word.in_frame, "parser not idle after a completed frame")
	`SFP_ASSERT_IMPL(a_frame_no_read, clk, arst_n, out_valid && out_word.frame_valid, out_word.read_data == 8'd0, "read data set on a byte word")
	`SFP_ASSERT_IMPL(a_no_frame_zero, clk, arst_n, out_valid && !out_word.frame_valid, out_word.frame_port == 8'd0 && out_word.frame_length == 8'd0, "frame fields set without a valid frame")

endmodule

bind sync_frame_parser_top sfp_checker u_sfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
